>>> rtl/psis_pkg.sv
// Shared types and constants for the partial-sum index sequence generator.
package psis_pkg;

   localparam int GROUP_SIZE_DEF = 4;
   localparam int MAX_DIM        = 64;

   localparam int SIZE_W  = 7;
   localparam int BASE_W  = 10;
   localparam int CSR_W   = 10;
   localparam int CIDX_W  = 3;
   localparam int FIDX_W  = 11;
   localparam int CHIDX_W = 13;
   localparam int ROW_W   = 6;
   localparam int COL_W   = 6;
   localparam int CYC_W   = 32;

   typedef enum logic [CIDX_W-1:0] {
      REG_COLS         = 3'd0,
      REG_ROWS         = 3'd1,
      REG_FILTERS      = 3'd2,
      REG_CHANS        = 3'd3,
      REG_TILES        = 3'd4,
      REG_FILTER_BASE  = 3'd5,
      REG_CHANNEL_BASE = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [SIZE_W-1:0] cols;
      logic [SIZE_W-1:0] rows;
      logic [SIZE_W-1:0] filters;
      logic [SIZE_W-1:0] chans_per_tile;
      logic [SIZE_W-1:0] tiles;
      logic [BASE_W-1:0] filter_base;
      logic [BASE_W-1:0] channel_base;
   } cfg_type;

   typedef struct packed {
      logic [FIDX_W-1:0]  filter_index;
      logic [CHIDX_W-1:0] channel_idx;
      logic [ROW_W-1:0]   row_idx;
      logic [COL_W-1:0]   col_idx;
      logic [CYC_W-1:0]   cycle_number;
      logic               last_of_pass;
   } tuple_type;

endpackage

>>> rtl/psis_cfg.sv
// Configuration register file for the index sequence generator.
module psis_cfg
   import psis_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CIDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]  csr_wdata,
   output cfg_type           cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_COLS:         cfg_in.cols           = csr_wdata[SIZE_W-1:0];
            REG_ROWS:         cfg_in.rows           = csr_wdata[SIZE_W-1:0];
            REG_FILTERS:      cfg_in.filters        = csr_wdata[SIZE_W-1:0];
            REG_CHANS:        cfg_in.chans_per_tile = csr_wdata[SIZE_W-1:0];
            REG_TILES:        cfg_in.tiles          = csr_wdata[SIZE_W-1:0];
            REG_FILTER_BASE:  cfg_in.filter_base    = csr_wdata[BASE_W-1:0];
            REG_CHANNEL_BASE: cfg_in.channel_base   = csr_wdata[BASE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cols           <= SIZE_W'(1);
         cfg_ff.rows           <= SIZE_W'(1);
         cfg_ff.filters        <= SIZE_W'(1);
         cfg_ff.chans_per_tile <= SIZE_W'(1);
         cfg_ff.tiles          <= SIZE_W'(1);
         cfg_ff.filter_base    <= '0;
         cfg_ff.channel_base   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/psis_core.sv
// Loop counters, committed position and tuple formation for one step.
module psis_core
   import psis_pkg::*;
#(
   parameter int GROUP_SIZE = GROUP_SIZE_DEF
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      step,
   input  logic      start,
   input  cfg_type   cfg,
   output logic      emit,
   output tuple_type tuple
);

   localparam int PW    = $clog2(MAX_DIM);
   localparam int EW    = $clog2(MAX_DIM + 1);
   localparam int CMP_W = (EW > SIZE_W) ? EW : SIZE_W;
   localparam int GW    = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
   localparam int FS_W  = BASE_W + PW + 1;
   localparam int CS_W  = BASE_W + PW + CMP_W + 1;

   // Last legal value of a dimension: zero acts as one, oversize clamps.
   function automatic logic [CMP_W-1:0] last_of(input logic [SIZE_W-1:0] v);
      logic [CMP_W-1:0] w;
      w = CMP_W'(v);
      if (v == '0) return '0;
      else if (w > CMP_W'(MAX_DIM)) return CMP_W'(MAX_DIM - 1);
      else return w - CMP_W'(1);
   endfunction

   function automatic logic at_end(input logic [PW-1:0] p, input logic [CMP_W-1:0] l);
      return CMP_W'(p) >= l;
   endfunction

   logic [PW-1:0] cf_ff, cc_ff, ccol_ff, wf_ff, wc_ff, wcol_ff, row_ff, tile_ff;
   logic [PW-1:0] cf_in, cc_in, ccol_in, wf_in, wc_in, wcol_in, row_in, tile_in;
   logic [GW-1:0]    grp_ff, grp_in;
   logic [CYC_W-1:0] cnt_ff, cnt_in;
   logic             act_ff, act_in;

   logic [CMP_W-1:0] l_col, l_row, l_fil, l_chn, l_til, eff_chn;
   logic [PW-1:0]    cur_f, cur_c, cur_col, cur_row, cur_tile;
   logic [PW-1:0]    nf, nc, ncol;
   logic [GW-1:0]    cur_grp;
   logic             active_now, last;
   logic [FS_W-1:0]  fsum;
   logic [CS_W-1:0]  csum;

   always_comb begin
      l_col   = last_of(cfg.cols);
      l_row   = last_of(cfg.rows);
      l_fil   = last_of(cfg.filters);
      l_chn   = last_of(cfg.chans_per_tile);
      l_til   = last_of(cfg.tiles);
      eff_chn = l_chn + CMP_W'(1);

      // A start clears the position, row, tile and group before the first tuple is formed; the cycle count is kept.
      cur_f    = start ? '0 : wf_ff;
      cur_c    = start ? '0 : wc_ff;
      cur_col  = start ? '0 : wcol_ff;
      cur_row  = start ? '0 : row_ff;
      cur_tile = start ? '0 : tile_ff;
      cur_grp  = start ? '0 : grp_ff;
      active_now = start ? !(l_fil == '0 && l_chn == '0 && l_col == '0) : act_ff;

      // Advance working position: channel fastest, then column, then filter.
      nf = cur_f; nc = cur_c; ncol = cur_col;
      if (at_end(cur_c, l_chn)) begin
         nc = '0;
         if (at_end(cur_col, l_col)) begin
            ncol = '0;
            if (at_end(cur_f, l_fil)) begin
               nc   = PW'(l_chn);
               ncol = PW'(l_col);
               nf   = PW'(l_fil);
            end else begin
               nf = cur_f + PW'(1);
            end
         end else begin
            ncol = cur_col + PW'(1);
         end
      end else begin
         nc = cur_c + PW'(1);
      end

      cf_in   = start ? '0 : cf_ff;
      cc_in   = start ? '0 : cc_ff;
      ccol_in = start ? '0 : ccol_ff;
      wf_in   = cur_f;
      wc_in   = cur_c;
      wcol_in = cur_col;
      row_in  = cur_row;
      tile_in = cur_tile;
      grp_in  = cur_grp;
      act_in  = active_now;
      cnt_in  = cnt_ff;
      last    = 1'b0;

      if (active_now) begin
         cnt_in  = cnt_ff + CYC_W'(1);
         wf_in   = nf;
         wc_in   = nc;
         wcol_in = ncol;
         if (cur_grp >= GW'(GROUP_SIZE - 1)) begin
            grp_in = '0;
            if (CMP_W'(cur_tile) >= l_til) begin
               tile_in = '0;
               if (CMP_W'(cur_row) >= l_row) begin
                  // All rows and tiles done: commit the advanced position.
                  row_in  = '0;
                  cf_in   = nf;
                  cc_in   = nc;
                  ccol_in = ncol;
                  if (at_end(nf, l_fil) && at_end(nc, l_chn) && at_end(ncol, l_col)) begin
                     act_in = 1'b0;
                     last   = 1'b1;
                  end
               end else begin
                  row_in = cur_row + PW'(1);
               end
            end else begin
               tile_in = cur_tile + PW'(1);
            end
            wf_in   = cf_in;
            wc_in   = cc_in;
            wcol_in = ccol_in;
         end else begin
            grp_in = cur_grp + GW'(1);
         end
      end

      fsum = FS_W'(cfg.filter_base) + FS_W'(cur_f);
      csum = CS_W'(cfg.channel_base) + CS_W'(cur_c) + CS_W'(cur_tile) * CS_W'(eff_chn);

      emit               = active_now;
      tuple.filter_index = fsum[FIDX_W-1:0];
      tuple.channel_idx  = csum[CHIDX_W-1:0];
      tuple.row_idx      = ROW_W'(cur_row);
      tuple.col_idx      = COL_W'(cur_col);
      tuple.cycle_number = cnt_ff;
      tuple.last_of_pass = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cf_ff   <= '0;
         cc_ff   <= '0;
         ccol_ff <= '0;
         wf_ff   <= '0;
         wc_ff   <= '0;
         wcol_ff <= '0;
         row_ff  <= '0;
         tile_ff <= '0;
         grp_ff  <= '0;
         cnt_ff  <= CYC_W'(1);
         act_ff  <= 1'b0;
      end else if (step) begin
         cf_ff   <= cf_in;
         cc_ff   <= cc_in;
         ccol_ff <= ccol_in;
         wf_ff   <= wf_in;
         wc_ff   <= wc_in;
         wcol_ff <= wcol_in;
         row_ff  <= row_in;
         tile_ff <= tile_in;
         grp_ff  <= grp_in;
         cnt_ff  <= cnt_in;
         act_ff  <= act_in;
      end
   end

endmodule

>>> rtl/psum_index_sequence_generator.sv
// Top level: request register, sequencer core and result register.
// The request register feeds the core, whose tuple the result register captures.
// One request per cycle unless stalled; loop counters update in a single step.
// A request produces no result when no pass is active after its start bit applies.
// Reset (synchronous, active high) clears the pass, counters and both stage
// valids; sizes return to 1, bases to 0 and the cycle number to 1.
module psum_index_sequence_generator
   import psis_pkg::*;
#(
   parameter int GROUP_SIZE = GROUP_SIZE_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_start_pass,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FIDX_W-1:0]  rsp_filter_index,
   output logic [CHIDX_W-1:0] rsp_channel_idx,
   output logic [ROW_W-1:0]   rsp_row_idx,
   output logic [COL_W-1:0]   rsp_col_idx,
   output logic [CYC_W-1:0]   rsp_cycle_number,
   output logic               rsp_last_of_pass,
   input  logic               csr_we,
   input  logic [CIDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   cfg_type   cfg;
   tuple_type tuple;
   tuple_type rsp_ff;
   logic      emit;

   logic req_valid_ff, req_start_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_open;
   logic step;

   psis_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The result register can take a new tuple when empty or being drained.
   assign out_open  = !rsp_valid_ff || !rsp_stall;
   // Advance the held request into the core only when its result has a home.
   assign step      = req_valid_ff && out_open;
   // Hold the request register while its occupant is blocked.
   assign req_stall = req_valid_ff && !out_open;

   psis_core #(
      .GROUP_SIZE (GROUP_SIZE)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .start (req_start_ff),
      .cfg   (cfg),
      .emit  (emit),
      .tuple (tuple)
   );

   assign rsp_valid_in = step && emit;

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_start_ff <= req_start_pass;
      end
   end

   // Result register: drop the old tuple once taken, load the new one.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_open) begin
         rsp_ff <= tuple;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filter_index = rsp_ff.filter_index;
   assign rsp_channel_idx  = rsp_ff.channel_idx;
   assign rsp_row_idx      = rsp_ff.row_idx;
   assign rsp_col_idx      = rsp_ff.col_idx;
   assign rsp_cycle_number = rsp_ff.cycle_number;
   assign rsp_last_of_pass = rsp_ff.last_of_pass;

endmodule
